// ===== design/aats_pkg.sv =====
// Shared types, constants and command structs for the await-aware task scheduler.
package aats_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 5;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef logic [ID_W-1:0] id_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADID = 2'd3;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_FINISH   = 3'd1,
        OP_FREE     = 3'd2,
        OP_WAIT     = 3'd3,
        OP_CURRENT  = 3'd4,
        OP_NEXT     = 3'd5
    } op_t;

    // deque moves applied to the whole cell row at once
    typedef enum logic [2:0] {
        DQ_HOLD = 3'd0,
        DQ_SHL  = 3'd1,
        DQ_SETF = 3'd2,
        DQ_WRAT = 3'd3,
        DQ_ROT  = 3'd4
    } dq_op_t;

    typedef struct packed {
        dq_op_t           op;
        id_t              val;
        logic [IDX_W-1:0] pos;
    } dq_cmd_t;

    typedef struct packed {
        logic q_clr_en;
        id_t  q_clr_id;
        logic q_set_en;
        id_t  q_set_id;
        logic aw_we;
        id_t  aw_id;
        id_t  aw_val;
    } tk_cmd_t;

    typedef struct packed {
        id_t        cur;
        id_t        nxt;
        logic [1:0] st;
    } res_t;

endpackage

// ===== design/aats_cell.sv =====
// One scheduler cell: a deque slot plus the awaiter and queued mark of one task.
module aats_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [aats_pkg::IDX_W-1:0] slot_idx,
    input  aats_pkg::id_t             task_num,
    input  aats_pkg::dq_cmd_t         dq_cmd,
    input  aats_pkg::tk_cmd_t         tk_cmd,
    input  aats_pkg::id_t             right_slot,
    output aats_pkg::id_t             slot,
    output aats_pkg::id_t             awaiter,
    output logic                      queued
);
    import aats_pkg::*;

    id_t  slot_reg, slot_next;
    id_t  aw_reg, aw_next;
    logic q_reg, q_next;

    always_comb
    begin
        slot_next = slot_reg;
        unique case (dq_cmd.op)
            DQ_HOLD: slot_next = slot_reg;
            DQ_SHL:  slot_next = right_slot;
            DQ_SETF:
            begin
                if (slot_idx == '0)
                    slot_next = dq_cmd.val;
            end
            DQ_WRAT:
            begin
                if (slot_idx == dq_cmd.pos)
                    slot_next = dq_cmd.val;
            end
            DQ_ROT:
            begin
                if (slot_idx == dq_cmd.pos)
                    slot_next = dq_cmd.val;
                else
                    slot_next = right_slot;
            end
            default: slot_next = slot_reg;
        endcase
    end

    // set wins over clear: a task popped and pushed again stays queued
    always_comb
    begin
        q_next  = q_reg;
        aw_next = aw_reg;
        if (tk_cmd.q_clr_en && tk_cmd.q_clr_id == task_num)
            q_next = 1'b0;
        if (tk_cmd.q_set_en && tk_cmd.q_set_id == task_num)
            q_next = 1'b1;
        if (tk_cmd.aw_we && tk_cmd.aw_id == task_num)
            aw_next = tk_cmd.aw_val;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= 1'b0;
            aw_reg <= '0;
        end
        else
        begin
            q_reg  <= q_next;
            aw_reg <= aw_next;
        end
    end

    assign slot    = slot_reg;
    assign awaiter = aw_reg;
    assign queued  = q_reg;

endmodule

// ===== design/aats_ctrl.sv =====
// Request decode: turns one opcode into row commands, the new count and the result.
module aats_ctrl (
    input  logic                                        fire,
    input  logic [2:0]                                  opcode,
    input  aats_pkg::id_t                               task_id,
    input  logic [aats_pkg::CNT_W-1:0]                  count,
    input  aats_pkg::id_t                               slot0,
    input  aats_pkg::id_t                               slot1,
    input  aats_pkg::id_t [aats_pkg::MAX_TASKS-1:0]     awaiter_vec,
    input  logic [aats_pkg::MAX_TASKS-1:0]              queued_vec,
    output aats_pkg::dq_cmd_t                           dq_cmd,
    output aats_pkg::tk_cmd_t                           tk_cmd,
    output logic [aats_pkg::CNT_W-1:0]                  count_next,
    output aats_pkg::res_t                              result
);
    import aats_pkg::*;

    localparam id_t             MAX_ID  = ID_W'(MAX_TASKS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    id_t              front, tid_m1, cur_m1, par, par_m1;
    logic [IDX_W-1:0] q_addr;
    logic [CNT_W-1:0] cnt_m1;
    logic             id_ok, par_ok, q_rd, q_par, q_tid, empty, multi;

    always_comb
    begin
        empty  = (count == '0);
        multi  = (count > CNT_ONE);
        front  = empty ? '0 : slot0;
        cnt_m1 = count - CNT_ONE;
        tid_m1 = task_id - ID_W'(1);
        cur_m1 = slot0 - ID_W'(1);
        id_ok  = (task_id != '0) && (task_id <= MAX_ID);
        par    = awaiter_vec[cur_m1[IDX_W-1:0]];
        par_m1 = par - ID_W'(1);
        par_ok = (par != '0) && (par <= MAX_ID);
        // one queued lookup per request: the parent for finish, the task otherwise
        q_addr = (opcode == OP_FINISH) ? par_m1[IDX_W-1:0] : tid_m1[IDX_W-1:0];
        q_rd   = queued_vec[q_addr];
        // marks as seen after the front task has been popped
        q_par  = q_rd && (par != slot0);
        q_tid  = q_rd && (task_id != slot0);

        dq_cmd     = '{op: DQ_HOLD, val: '0, pos: '0};
        tk_cmd     = '0;
        count_next = count;
        result     = '{cur: front, nxt: front, st: ST_OK};

        unique case (op_t'(opcode))
            OP_REGISTER:
            begin
                if (!id_ok)
                    result.st = ST_BADID;
                else if (count >= CNT_MAX)
                    result.st = ST_FULL;
                else
                begin
                    dq_cmd          = '{op: DQ_WRAT, val: task_id, pos: count[IDX_W-1:0]};
                    count_next      = count + CNT_ONE;
                    tk_cmd.q_set_en = 1'b1;
                    tk_cmd.q_set_id = task_id;
                    tk_cmd.aw_we    = 1'b1;
                    tk_cmd.aw_id    = task_id;
                    tk_cmd.aw_val   = '0;
                    result.cur      = empty ? task_id : slot0;
                    result.nxt      = empty ? task_id : slot0;
                end
            end
            OP_FINISH:
            begin
                if (empty)
                    result = '{cur: '0, nxt: '0, st: ST_EMPTY};
                else
                begin
                    result.cur      = slot0;
                    tk_cmd.q_clr_en = 1'b1;
                    tk_cmd.q_clr_id = slot0;
                    if (par_ok && !q_par)
                    begin
                        // pop and resume the parent in the same slot
                        tk_cmd.q_set_en = 1'b1;
                        tk_cmd.q_set_id = par;
                        dq_cmd          = '{op: DQ_SETF, val: par, pos: '0};
                        result.nxt      = par;
                    end
                    else
                    begin
                        dq_cmd     = '{op: DQ_SHL, val: '0, pos: '0};
                        count_next = cnt_m1;
                        result.nxt = multi ? slot1 : '0;
                        if (!multi)
                            result.st = ST_EMPTY;
                    end
                end
            end
            OP_FREE:
            begin
                if (!id_ok || q_rd)
                    result.st = ST_BADID;
                else
                begin
                    tk_cmd.q_clr_en = 1'b1;
                    tk_cmd.q_clr_id = task_id;
                    tk_cmd.aw_we    = 1'b1;
                    tk_cmd.aw_id    = task_id;
                    tk_cmd.aw_val   = '0;
                end
            end
            OP_WAIT:
            begin
                if (!id_ok)
                    result.st = ST_BADID;
                else if (empty)
                    result = '{cur: '0, nxt: '0, st: ST_EMPTY};
                else
                begin
                    result.cur      = slot0;
                    tk_cmd.q_clr_en = 1'b1;
                    tk_cmd.q_clr_id = slot0;
                    tk_cmd.aw_we    = 1'b1;
                    tk_cmd.aw_id    = task_id;
                    tk_cmd.aw_val   = slot0;
                    if (!q_tid)
                    begin
                        tk_cmd.q_set_en = 1'b1;
                        tk_cmd.q_set_id = task_id;
                        dq_cmd          = '{op: DQ_SETF, val: task_id, pos: '0};
                        result.nxt      = task_id;
                    end
                    else
                    begin
                        dq_cmd     = '{op: DQ_SHL, val: '0, pos: '0};
                        count_next = cnt_m1;
                        result.nxt = multi ? slot1 : '0;
                    end
                end
            end
            OP_CURRENT:
            begin
                if (empty)
                    result = '{cur: '0, nxt: '0, st: ST_EMPTY};
            end
            OP_NEXT:
            begin
                if (empty)
                    result = '{cur: '0, nxt: '0, st: ST_EMPTY};
                else
                begin
                    dq_cmd     = '{op: DQ_ROT, val: slot0, pos: cnt_m1[IDX_W-1:0]};
                    result.cur = slot0;
                    result.nxt = multi ? slot1 : slot0;
                end
            end
            default:
            begin
                result = '{cur: front, nxt: front, st: ST_OK};
            end
        endcase

        if (!fire)
        begin
            dq_cmd     = '{op: DQ_HOLD, val: '0, pos: '0};
            tk_cmd     = '0;
            count_next = count;
        end
    end

endmodule

// ===== design/await_aware_task_scheduler.sv =====
// Top level of the await-aware task scheduler: cell row, control and result register.
// One request is taken per cycle and its result appears in the output register on the
// next cycle; with the result side draining, the block sustains one request per clock.
// The ready deque lives in a row of cells, one slot each, with the front in the first
// cell: pops, resumes at the front, pushes at the back and rotations are all done by
// every cell loading from its right neighbor or from the request value.
// Each cell also holds the awaiter and queued mark of one task; the one awaiter lookup
// and the one queued lookup of a request are selects across the row. Requests are held
// off only while an unread result sits in the output register. No clearing pass.
module await_aware_task_scheduler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  aats_pkg::id_t       task_id,
    output logic                out_valid,
    input  logic                out_stall,
    output aats_pkg::id_t       cur_task,
    output aats_pkg::id_t       nxt_task,
    output logic [1:0]          status
);
    import aats_pkg::*;

    logic                       fire;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    res_t                       res_reg, res;
    dq_cmd_t                    dq_cmd;
    tk_cmd_t                    tk_cmd;
    id_t [MAX_TASKS-1:0]        slot_vec;
    id_t [MAX_TASKS-1:0]        right_vec;
    id_t [MAX_TASKS-1:0]        awaiter_vec;
    logic [MAX_TASKS-1:0]       queued_vec;

    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    aats_ctrl u_ctrl (
        .fire        (fire),
        .opcode      (opcode),
        .task_id     (task_id),
        .count       (count_reg),
        .slot0       (slot_vec[0]),
        .slot1       (slot_vec[1]),
        .awaiter_vec (awaiter_vec),
        .queued_vec  (queued_vec),
        .dq_cmd      (dq_cmd),
        .tk_cmd      (tk_cmd),
        .count_next  (count_next),
        .result      (res)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            if (gi == MAX_TASKS - 1)
            begin : g_last
                assign right_vec[gi] = '0;
            end
            else
            begin : g_mid
                assign right_vec[gi] = slot_vec[gi+1];
            end

            aats_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .slot_idx   (IDX_W'(gi)),
                .task_num   (ID_W'(gi + 1)),
                .dq_cmd     (dq_cmd),
                .tk_cmd     (tk_cmd),
                .right_slot (right_vec[gi]),
                .slot       (slot_vec[gi]),
                .awaiter    (awaiter_vec[gi]),
                .queued     (queued_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign cur_task  = res_reg.cur;
    assign nxt_task  = res_reg.nxt;
    assign status    = res_reg.st;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("deque count above capacity");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.st == ST_FULL |=> $stable(count_reg))
        else $error("full register changed the deque count");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg && res_reg == $past(res))
        else $error("accepted request did not load its result");

    a_ok_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status == ST_OK && nxt_task == '0 |-> count_reg == '0)
        else $error("ok result with no next task but deque not empty");

endmodule

// ===== tb/await_aware_task_scheduler_tb.sv =====
// Self-checking testbench for the await-aware task scheduler with a scoreboard class.
module await_aware_task_scheduler_tb;
    import aats_pkg::*;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int         N_RANDOM = 1750;
    localparam int         LONG_HOLD = 60;
    localparam int         CYCLE_LIMIT = 200000;

    class sched_scoreboard;
        id_t  slot [MAX_TASKS];
        int   head;
        int   fill;
        id_t  parent [MAX_TASKS];
        bit   queued [MAX_TASKS];
        res_t awaited [$];
        int   errors;

        function new();
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot[i]   = '0;
                parent[i] = '0;
                queued[i] = 1'b0;
            end
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function bit valid_id(id_t id);
            return id >= 1 && id <= MAX_TASKS;
        endfunction

        function id_t front();
            return (fill == 0) ? id_t'(0) : slot[head];
        endfunction

        function id_t pop_front();
            id_t v;
            v    = slot[head];
            head = (head + 1) % MAX_TASKS;
            fill--;
            return v;
        endfunction

        function void push_front(id_t v);
            head       = (head + MAX_TASKS - 1) % MAX_TASKS;
            slot[head] = v;
            fill++;
        endfunction

        function void push_back(id_t v);
            slot[(head + fill) % MAX_TASKS] = v;
            fill++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // accepted request: advance the model and queue the expected result
        function void note_request(logic [2:0] op, id_t id);
            res_t r;
            id_t  popped;
            id_t  par;
            bit   show_front;
            r.cur      = '0;
            r.nxt      = '0;
            r.st       = ST_OK;
            show_front = 1'b0;
            case (op)
                OP_REGISTER:
                begin
                    show_front = 1'b1;
                    if (!valid_id(id))
                        r.st = ST_BADID;
                    else if (fill == MAX_TASKS)
                        r.st = ST_FULL;
                    else
                    begin
                        parent[id-1] = '0;
                        queued[id-1] = 1'b1;
                        push_back(id);
                    end
                end
                OP_FINISH:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        popped           = pop_front();
                        queued[popped-1] = 1'b0;
                        par              = parent[popped-1];
                        r.cur            = popped;
                        if (par != 0 && !queued[par-1])
                        begin
                            queued[par-1] = 1'b1;
                            push_front(par);
                            r.nxt = par;
                        end
                        else
                        begin
                            r.nxt = front();
                            if (fill == 0)
                                r.st = ST_EMPTY;
                        end
                    end
                end
                OP_FREE:
                begin
                    show_front = 1'b1;
                    if (!valid_id(id) || queued[id-1])
                        r.st = ST_BADID;
                    else
                        parent[id-1] = '0;
                end
                OP_WAIT:
                begin
                    if (!valid_id(id))
                    begin
                        r.st       = ST_BADID;
                        show_front = 1'b1;
                    end
                    else if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        popped           = pop_front();
                        queued[popped-1] = 1'b0;
                        parent[id-1]     = popped;
                        if (!queued[id-1])
                        begin
                            queued[id-1] = 1'b1;
                            push_front(id);
                        end
                        r.cur = popped;
                        r.nxt = front();
                    end
                end
                OP_CURRENT:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                        show_front = 1'b1;
                end
                OP_NEXT:
                begin
                    if (fill == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        popped = pop_front();
                        push_back(popped);
                        r.cur = popped;
                        r.nxt = front();
                    end
                end
                default:
                    show_front = 1'b1;
            endcase
            if (show_front)
            begin
                r.cur = front();
                r.nxt = r.cur;
            end
            awaited.push_back(r);
        endfunction

        function void check_result(id_t cur, id_t nxt, logic [1:0] st);
            res_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: cur=%0d nxt=%0d st=%0d", cur, nxt, st);
                return;
            end
            want = awaited.pop_front();
            if (want.cur !== cur || want.nxt !== nxt || want.st !== st)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected cur=%0d nxt=%0d st=%0d, got cur=%0d nxt=%0d st=%0d",
                             want.cur, want.nxt, want.st, cur, nxt, st);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] opcode;
    id_t        task_id;
    logic       out_valid;
    logic       out_stall;
    id_t        cur_task;
    id_t        nxt_task;
    logic [1:0] status;

    sched_scoreboard sb = new();
    bit hold_req = 1'b0;
    bit calm     = 1'b0;
    int cycles   = 0;

    await_aware_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cur_task  (cur_task),
        .nxt_task  (nxt_task),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(opcode, task_id);
            if (out_valid && !out_stall)
                sb.check_result(cur_task, nxt_task, status);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int k;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                k = LONG_HOLD;
            end
            else
                k = calm ? 0 : $urandom_range(0, 8);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // call on a clock edge; returns on the edge where the request is taken
    task automatic send_request(input logic [2:0] op, input id_t id);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode   <= op;
        task_id  <= id;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // the first edge lets the monitor note a request taken on the calling edge
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         i;
        int         profile;
        int         reg_pct;
        int         fin_pct;
        int         roll;
        logic [2:0] op;
        id_t        id;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= OP_CURRENT;
        task_id  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue on every opcode that reports
        send_request(OP_CURRENT, 5'd0);
        send_request(OP_NEXT, 5'd0);
        send_request(OP_FINISH, 5'd0);
        send_request(OP_WAIT, 5'd5);
        // bad ids: zero and above the table
        send_request(OP_REGISTER, 5'd0);
        send_request(OP_REGISTER, 5'd17);
        send_request(OP_REGISTER, 5'd31);
        send_request(OP_FREE, 5'd0);
        send_request(OP_WAIT, 5'd0);
        send_request(OP_REGISTER, 5'd1);
        send_request(OP_REGISTER, 5'd16);
        send_request(OP_REGISTER, 5'd1);    // same task queued twice
        send_request(OP_CURRENT, 5'd31);
        send_request(OP_NEXT, 5'd0);
        send_request(OP_FREE, 5'd1);        // queued task, refused
        send_request(OP_WAIT, 5'd2);
        send_request(OP_WAIT, 5'd3);
        send_request(OP_FINISH, 5'd0);      // resumes the awaiter
        send_request(OP_WAIT, 5'd4);
        send_request(OP_WAIT, 5'd4);        // parent overwritten
        send_request(OP_RSVD6, 5'd9);
        send_request(OP_RSVD7, 5'd30);
        send_request(OP_FREE, 5'd5);
        drain_results();

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
            begin
                profile = $urandom_range(0, 2);
                calm    = ($urandom_range(0, 3) == 0);
            end
            if (i == 600)
                hold_req = 1'b1;
            if (i == 1200)
                drain_results();
            // profile 0 fills the deque, profile 1 drains it
            reg_pct = (profile == 0) ? 55 : (profile == 1) ? 15 : 28;
            fin_pct = (profile == 1) ? 35 : 15;
            roll    = $urandom_range(0, 99);
            if (roll < reg_pct)
                op = OP_REGISTER;
            else if (roll < reg_pct + fin_pct)
                op = OP_FINISH;
            else
            begin
                case ($urandom_range(0, 8))
                    0, 1, 6: op = OP_WAIT;
                    2, 7:    op = OP_NEXT;
                    3:       op = OP_CURRENT;
                    4, 5:    op = OP_FREE;
                    default: op = ($urandom_range(0, 1) == 1) ? OP_RSVD7 : OP_RSVD6;
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                id = id_t'($urandom_range(0, 31));
            else
                id = id_t'($urandom_range(1, MAX_TASKS));
            send_request(op, id);
        end

        calm = 1'b0;
        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
